// ===== hw/rtl/pipc_pkg.sv =====
// Package: coordinate widths and types shared by the point-in-polygon block.
`timescale 1ns / 1ps
package pipc_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;

    typedef struct packed {
        coord_t query_x;
        coord_t query_y;
        coord_t vertex_x;
        coord_t vertex_y;
        logic   first_vertex;
        logic   last_vertex;
    } vertex_item_t;

endpackage

// ===== hw/rtl/pipc_if.sv =====
// Interfaces: vertex input channel and inside-result output channel.
`timescale 1ns / 1ps
interface pipc_vtx_if;
    logic                valid;
    logic                ready;
    pipc_pkg::coord_t    query_x;
    pipc_pkg::coord_t    query_y;
    pipc_pkg::coord_t    vertex_x;
    pipc_pkg::coord_t    vertex_y;
    logic                first_vertex;
    logic                last_vertex;

    modport source (
        output valid, query_x, query_y, vertex_x, vertex_y, first_vertex, last_vertex,
        input  ready
    );
    modport sink (
        input  valid, query_x, query_y, vertex_x, vertex_y, first_vertex, last_vertex,
        output ready
    );
endinterface

interface pipc_res_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (
        output valid, inside_res,
        input  ready
    );
    modport sink (
        input  valid, inside_res,
        output ready
    );
endinterface

// ===== hw/rtl/point_in_polygon_crossing.sv =====
// Top level: streaming even-odd ray-casting point-in-polygon test.
// A last vertex is held in stage_reg, then its result is registered in res_reg and shown on result_out.
// Throughput: one vertex per cycle; both edge tests run in parallel in one stage.
// A last vertex stalls only while the result register is full and not taken.
// Reset clears the stored start and previous vertex to zero and the parity to 0.
`timescale 1ns / 1ps
module point_in_polygon_crossing (
    input  logic              clk,
    input  logic              rst_n,
    pipc_vtx_if.sink          vertex_in,
    pipc_res_if.source        result_out
);

    pipc_pkg::vertex_item_t stage_reg;
    logic                   stage_valid_reg;
    pipc_pkg::coord_t       start_x_reg;
    pipc_pkg::coord_t       start_y_reg;
    pipc_pkg::coord_t       prior_x_reg;
    pipc_pkg::coord_t       prior_y_reg;
    logic                   parity_reg;
    logic                   res_valid_reg;
    logic                   res_reg;

    logic                   advance;
    logic                   in_fire;
    logic                   cross_prev;
    logic                   cross_close;
    logic                   parity_mid;
    logic                   parity_next;
    pipc_pkg::coord_t       start_x_next;
    pipc_pkg::coord_t       start_y_next;

    assign advance = stage_valid_reg &&
                     (!stage_reg.last_vertex || !res_valid_reg || result_out.ready);
    assign vertex_in.ready = !stage_valid_reg || advance;
    assign in_fire = vertex_in.valid && vertex_in.ready;

    // edge from the previous vertex to the current one
    pipc_edge u_edge_prev (
        .query_x (stage_reg.query_x),
        .query_y (stage_reg.query_y),
        .xi      (stage_reg.vertex_x),
        .yi      (stage_reg.vertex_y),
        .xj      (prior_x_reg),
        .yj      (prior_y_reg),
        .crosses (cross_prev)
    );

    assign start_x_next = stage_reg.first_vertex ? stage_reg.vertex_x : start_x_reg;
    assign start_y_next = stage_reg.first_vertex ? stage_reg.vertex_y : start_y_reg;

    // closing edge from the current vertex back to the start
    pipc_edge u_edge_close (
        .query_x (stage_reg.query_x),
        .query_y (stage_reg.query_y),
        .xi      (start_x_next),
        .yi      (start_y_next),
        .xj      (stage_reg.vertex_x),
        .yj      (stage_reg.vertex_y),
        .crosses (cross_close)
    );

    assign parity_mid  = stage_reg.first_vertex ? 1'b0 : (parity_reg ^ cross_prev);
    assign parity_next = parity_mid ^ (stage_reg.last_vertex && cross_close);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            prior_x_reg     <= '0;
            prior_y_reg     <= '0;
            parity_reg      <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                start_x_reg <= start_x_next;
                start_y_reg <= start_y_next;
                prior_x_reg <= stage_reg.vertex_x;
                prior_y_reg <= stage_reg.vertex_y;
                parity_reg  <= parity_next;
            end

            if (advance && stage_reg.last_vertex)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_reg.query_x      <= vertex_in.query_x;
            stage_reg.query_y      <= vertex_in.query_y;
            stage_reg.vertex_x     <= vertex_in.vertex_x;
            stage_reg.vertex_y     <= vertex_in.vertex_y;
            stage_reg.first_vertex <= vertex_in.first_vertex;
            stage_reg.last_vertex  <= vertex_in.last_vertex;
        end
        if (advance && stage_reg.last_vertex)
        begin
            res_reg <= parity_next;
        end
    end

    assign result_out.valid      = res_valid_reg;
    assign result_out.inside_res = res_reg;

endmodule

// ===== hw/rtl/pipc_edge.sv =====
// Edge crossing test: does the ray from the query point cross one polygon edge.
`timescale 1ns / 1ps
module pipc_edge (
    input  pipc_pkg::coord_t query_x,
    input  pipc_pkg::coord_t query_y,
    input  pipc_pkg::coord_t xi,
    input  pipc_pkg::coord_t yi,
    input  pipc_pkg::coord_t xj,
    input  pipc_pkg::coord_t yj,
    output logic             crosses
);

    pipc_pkg::diff_t dy;
    pipc_pkg::diff_t qx_rel;
    pipc_pkg::diff_t qy_rel;
    pipc_pkg::diff_t dx;
    pipc_pkg::prod_t lhs;
    pipc_pkg::prod_t rhs;
    logic            straddle;

    assign straddle = (yi > query_y) != (yj > query_y);

    assign dy     = pipc_pkg::diff_t'(yj)      - pipc_pkg::diff_t'(yi);
    assign qx_rel = pipc_pkg::diff_t'(query_x) - pipc_pkg::diff_t'(xi);
    assign qy_rel = pipc_pkg::diff_t'(query_y) - pipc_pkg::diff_t'(yi);
    assign dx     = pipc_pkg::diff_t'(xj)      - pipc_pkg::diff_t'(xi);

    assign lhs = pipc_pkg::prod_t'(qx_rel) * pipc_pkg::prod_t'(dy);
    assign rhs = pipc_pkg::prod_t'(dx)     * pipc_pkg::prod_t'(qy_rel);

    // flip the comparison when dy is negative
    assign crosses = straddle && ((dy > 0) ? (lhs < rhs) : (rhs < lhs));

endmodule

// ===== bench/pipc_checker.sv =====
// Checker: watches both channels, predicts the inside bit per polygon, compares results.
`timescale 1ns / 1ps
module pipc_checker (
    input  logic clk,
    input  logic rst_n,
    pipc_vtx_if  vtx,
    pipc_res_if  res,
    output int   fail_count,
    output int   pending
);

    pipc_pkg::coord_t start_x;
    pipc_pkg::coord_t start_y;
    pipc_pkg::coord_t prior_x;
    pipc_pkg::coord_t prior_y;
    logic             parity;
    logic             inside_q[$];
    int               errors = 0;

    // Edge from (xj, yj) to (xi, yi): does a ray going right from the query cross it?
    // The crossing compare is multiplied through by dy, so flip it when dy is negative.
    function automatic logic edge_toggles(pipc_pkg::coord_t qx, pipc_pkg::coord_t qy,
                                          pipc_pkg::coord_t xi, pipc_pkg::coord_t yi,
                                          pipc_pkg::coord_t xj, pipc_pkg::coord_t yj);
        longint dy;
        longint lhs;
        longint rhs;
        if ((yi > qy) == (yj > qy))
            return 1'b0;
        dy  = longint'(yj) - longint'(yi);
        lhs = (longint'(qx) - longint'(xi)) * dy;
        rhs = (longint'(xj) - longint'(xi)) * (longint'(qy) - longint'(yi));
        return (dy > 0) ? (lhs < rhs) : (rhs < lhs);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start_x = '0;
            start_y = '0;
            prior_x = '0;
            prior_y = '0;
            parity  = 1'b0;
            inside_q.delete();
        end
        else
        begin
            // check the outgoing transaction first: it belongs to an older polygon
            if (res.valid && res.ready)
            begin
                if (inside_q.size() == 0)
                    report_mismatch($sformatf("unexpected result inside_res=%0b",
                                              res.inside_res));
                else
                begin
                    if (res.inside_res !== inside_q[0])
                        report_mismatch($sformatf("inside_res=%0b, predicted %0b",
                                                  res.inside_res, inside_q[0]));
                    void'(inside_q.pop_front());
                end
            end
            if (vtx.valid && vtx.ready)
            begin
                if (vtx.first_vertex)
                begin
                    parity  = 1'b0;
                    start_x = vtx.vertex_x;
                    start_y = vtx.vertex_y;
                end
                else if (edge_toggles(vtx.query_x, vtx.query_y, vtx.vertex_x, vtx.vertex_y,
                                      prior_x, prior_y))
                    parity = ~parity;
                prior_x = vtx.vertex_x;
                prior_y = vtx.vertex_y;
                if (vtx.last_vertex)
                begin
                    // close the polygon back to its start vertex
                    if (edge_toggles(vtx.query_x, vtx.query_y, start_x, start_y,
                                     vtx.vertex_x, vtx.vertex_y))
                        parity = ~parity;
                    inside_q.push_back(parity);
                end
            end
        end
        fail_count <= errors;
        pending    <= inside_q.size();
    end

endmodule

// ===== bench/point_in_polygon_crossing_test.sv =====
// Testbench top: clock, reset, vertex stream stimulus, result stalls and the verdict.
`timescale 1ns / 1ps
module point_in_polygon_crossing_test;

    localparam int ITEM_TARGET = 1400;
    localparam int QUIET_TAIL  = 200;
    localparam int STRETCH     = 150;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {SPREAD_NEAR, SPREAD_FULL, SPREAD_EXTREME} spread_t;

    logic        clk = 1'b0;
    logic        rst_n;
    int          cycle_count = 0;
    int          fail_count;
    int          pending;
    bit          idle_on;
    int unsigned sink_hold;
    int          items_sent;

    pipc_vtx_if vtx_ch ();
    pipc_res_if res_ch ();

    point_in_polygon_crossing i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .vertex_in  (vtx_ch),
        .result_out (res_ch)
    );

    pipc_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .vtx        (vtx_ch),
        .res        (res_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: drop ready in random bursts while idling is on
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            sink_hold    <= 0;
        end
        else if (sink_hold != 0)
            sink_hold <= sink_hold - 1;
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            res_ch.ready <= 1'b0;
            sink_hold    <= $urandom_range(0, 14);
        end
        else
            res_ch.ready <= 1'b1;
    end

    task automatic send_vertex(int qx, int qy, int vx, int vy, int first, int last);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            vtx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        vtx_ch.valid        <= 1'b1;
        vtx_ch.query_x      <= pipc_pkg::coord_t'(qx);
        vtx_ch.query_y      <= pipc_pkg::coord_t'(qy);
        vtx_ch.vertex_x     <= pipc_pkg::coord_t'(vx);
        vtx_ch.vertex_y     <= pipc_pkg::coord_t'(vy);
        vtx_ch.first_vertex <= 1'(first);
        vtx_ch.last_vertex  <= 1'(last);
        do
            @(posedge clk);
        while (vtx_ch.ready !== 1'b1);
        items_sent++;
    endtask

    function automatic pipc_pkg::coord_t pick_coord(spread_t spread, int centre,
                                                    int unsigned span);
        case (spread)
            SPREAD_NEAR:
                return pipc_pkg::coord_t'(centre + int'($urandom_range(0, 2 * span))
                                          - int'(span));
            SPREAD_EXTREME:
                case ($urandom_range(0, 4))
                    0: return pipc_pkg::coord_t'(-32768);
                    1: return pipc_pkg::coord_t'(32767);
                    2: return pipc_pkg::coord_t'(0);
                    3: return pipc_pkg::coord_t'(-1);
                    default: return pipc_pkg::coord_t'($urandom);
                endcase
            default:
                return pipc_pkg::coord_t'($urandom);
        endcase
    endfunction

    // open_start: leave out the first-vertex mark; drift: move the query on every vertex
    task automatic send_polygon(int count, spread_t spread, bit open_start, bit drift);
        int               cx;
        int               cy;
        int unsigned      span;
        pipc_pkg::coord_t qx;
        pipc_pkg::coord_t qy;
        cx = int'($urandom_range(0, 32000)) - 16000;
        cy = int'($urandom_range(0, 32000)) - 16000;
        case ($urandom_range(0, 3))
            0: span = 4;
            1: span = 64;
            2: span = 3000;
            default: span = 16000;
        endcase
        qx = pick_coord(spread, cx, span / 2);
        qy = pick_coord(spread, cy, span / 2);
        for (int i = 0; i < count; i++)
        begin
            if (drift)
            begin
                qx = pick_coord(spread, cx, span / 2);
                qy = pick_coord(spread, cy, span / 2);
            end
            send_vertex(int'(qx), int'(qy), int'(pick_coord(spread, cx, span)),
                        int'(pick_coord(spread, cy, span)),
                        int'((i == 0) && !open_start), int'(i == count - 1));
        end
    endtask

    initial
    begin
        int      kind;
        int      count;
        int      next_switch;
        bit      paused;
        spread_t spread;

        rst_n               <= 1'b0;
        vtx_ch.valid        <= 1'b0;
        vtx_ch.query_x      <= '0;
        vtx_ch.query_y      <= '0;
        vtx_ch.vertex_x     <= '0;
        vtx_ch.vertex_y     <= '0;
        vtx_ch.first_vertex <= 1'b0;
        vtx_ch.last_vertex  <= 1'b0;
        idle_on             <= 1'b1;
        items_sent  = 0;
        next_switch = STRETCH;
        paused      = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no first vertex since reset: edges start from the cleared previous vertex
        send_vertex(0, 50, 100, 100, 0, 0);
        send_vertex(0, 50, -100, 100, 0, 1);
        // state is held after a result, so a bare last vertex continues from it
        send_vertex(10, 10, 20, 20, 0, 1);
        // first and last together: degenerate closing edge
        send_vertex(5, 5, 7, 7, 1, 1);
        // full-range square around the origin
        send_vertex(0, 0, -32768, -32768, 1, 0);
        send_vertex(0, 0, 32767, -32768, 0, 0);
        send_vertex(0, 0, 32767, 32767, 0, 0);
        send_vertex(0, 0, -32768, 32767, 0, 1);
        // query sitting on a corner of the same square
        send_vertex(32767, 32767, -32768, -32768, 1, 0);
        send_vertex(32767, 32767, 32767, -32768, 0, 0);
        send_vertex(32767, 32767, 32767, 32767, 0, 0);
        send_vertex(32767, 32767, -32768, 32767, 0, 1);
        // query on a horizontal edge
        send_vertex(0, 0, -10, 0, 1, 0);
        send_vertex(0, 0, 10, 0, 0, 0);
        send_vertex(0, 0, 10, 10, 0, 0);
        send_vertex(0, 0, -10, 10, 0, 1);
        // a vertex exactly at the query height
        send_vertex(0, 5, -10, 0, 1, 0);
        send_vertex(0, 5, 20, 5, 0, 0);
        send_vertex(0, 5, 10, 10, 0, 0);
        send_vertex(0, 5, -10, 10, 0, 1);
        // query at the most negative corner, widest triangle
        send_vertex(-32768, -32768, 0, 0, 1, 0);
        send_vertex(-32768, -32768, 32767, -32768, 0, 0);
        send_vertex(-32768, -32768, -32768, 32767, 0, 1);

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= ITEM_TARGET - QUIET_TAIL)
                idle_on <= 1'b0;
            else if (items_sent >= next_switch)
            begin
                idle_on <= ($urandom_range(0, 3) != 0);
                next_switch += STRETCH;
            end
            // hold off once until the result stream has fully drained
            if (!paused && items_sent >= ITEM_TARGET / 2)
            begin
                paused = 1'b1;
                vtx_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending != 0);
            end

            case ($urandom_range(0, 9))
                0: count = 1;
                1: count = 2;
                2: count = $urandom_range(9, 24);
                default: count = $urandom_range(3, 8);
            endcase
            kind = $urandom_range(0, 9);
            if (kind < 6)
                spread = SPREAD_NEAR;
            else if (kind < 8)
                spread = SPREAD_FULL;
            else
                spread = SPREAD_EXTREME;

            kind = $urandom_range(0, 99);
            if (kind < 75)
                send_polygon(count, spread, 1'b0, 1'b0);
            else if (kind < 85)
                repeat ($urandom_range(1, 4))
                    send_vertex(int'($urandom), int'($urandom), int'($urandom),
                                int'($urandom), int'($urandom_range(0, 1)),
                                int'($urandom_range(0, 1)));
            else if (kind < 93)
                send_polygon(count, spread, 1'b1, 1'b0);
            else
                send_polygon(count, spread, 1'b0, 1'b1);
        end

        vtx_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/pipc_pkg.sv
hw/rtl/pipc_if.sv
hw/rtl/pipc_edge.sv
hw/rtl/point_in_polygon_crossing.sv
bench/pipc_checker.sv
bench/point_in_polygon_crossing_test.sv
